// File: rtl/websocket_frame_deframer_unit_macros.svh
// Assertion macros shared by the deframer RTL files.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_IMP(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("wsfd: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("wsfd: next-cycle check failed");
`else
`define WSFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define WSFD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/wsfd_pkg.sv
// Types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsfd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_last;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       frame_last;
   } rsp_type;

   // One parser result plus its valid flag, handed to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } result_type;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASKKEY = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_PONG    = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;

   localparam logic [3:0] OP_CONT     = 4'h0;
   localparam logic [3:0] OP_RSV_LO   = 4'h3;  // reserved data opcodes lie above this
   localparam logic [3:0] OP_RSV_HI   = 4'h8;  // ... and below this
   localparam logic [3:0] OP_PING     = 4'h9;
   localparam logic [3:0] OP_CTRL_MAX = 4'hB;  // above this: reserved control opcodes

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// File: rtl/wsfd_parser.sv
// Per-byte frame parser: header, length, mask key and payload unmasking.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unit_macros.svh"
module wsfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  wsfd_pkg::req_type   req,
   output wsfd_pkg::result_type result
);
   import wsfd_pkg::*;

   phase_type   phase_ff,        phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [63:0] remaining_ff,    remaining_in;
   logic [31:0] mask_key_ff,     mask_key_in;
   logic [1:0]  mask_index_ff,   mask_index_in;
   logic        masked_ff,       masked_in;

   logic [3:0]  opcode;
   logic [6:0]  len7;
   logic [3:0]  count_dec;
   logic [63:0] remaining_dec;
   logic        payload_fin;
   logic        op_invalid;
   logic [7:0]  key_byte;

   assign opcode        = req.data_byte[3:0];
   assign len7          = req.data_byte[6:0];
   assign count_dec     = header_count_ff - 4'd1;
   assign remaining_dec = remaining_ff - 64'd1;
   assign payload_fin   = (remaining_dec == 64'd0);
   assign op_invalid    = ((opcode > OP_RSV_LO) && (opcode < OP_RSV_HI))
                          || (opcode > OP_CTRL_MAX);

   always_comb begin
      unique case (mask_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Next state
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      remaining_in    = remaining_ff;
      mask_key_in     = mask_key_ff;
      mask_index_in   = mask_index_ff;
      masked_in       = masked_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               if (op_invalid || opcode == OP_CONT || opcode == OP_PING) begin
                  phase_in = PH_DISCARD;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               masked_in    = req.data_byte[7];
               remaining_in = 64'd0;
               if (len7 == LEN_EXT16) begin
                  phase_in        = PH_EXTLEN;
                  header_count_in = EXT16_BYTES;
               end else if (len7 == LEN_EXT64) begin
                  phase_in        = PH_EXTLEN;
                  header_count_in = EXT64_BYTES;
               end else begin
                  remaining_in = {57'd0, len7};
                  if (req.data_byte[7]) begin
                     phase_in        = PH_MASKKEY;
                     header_count_in = KEY_BYTES;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
            end
            PH_EXTLEN: begin
               remaining_in    = {remaining_ff[55:0], req.data_byte};
               header_count_in = count_dec;
               if (count_dec == 4'd0) begin
                  if (masked_ff) begin
                     phase_in        = PH_MASKKEY;
                     header_count_in = KEY_BYTES;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
            end
            PH_MASKKEY: begin
               mask_key_in     = {mask_key_ff[23:0], req.data_byte};
               header_count_in = count_dec;
               if (count_dec == 4'd0) begin
                  mask_index_in = 2'd0;
                  phase_in      = (remaining_ff == 64'd0) ? PH_DISCARD : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               mask_index_in = mask_index_ff + 2'd1;
               remaining_in  = remaining_dec;
               if (payload_fin) begin
                  phase_in        = PH_HDR0;
                  header_count_in = 4'd0;
                  mask_index_in   = 2'd0;
               end
            end
            default: begin
            end
         endcase
         // End of buffer: drop whatever frame was in flight.
         if (req.buffer_last) begin
            phase_in        = PH_HDR0;
            header_count_in = 4'd0;
            remaining_in    = 64'd0;
            mask_key_in     = 32'd0;
            mask_index_in   = 2'd0;
            masked_in       = 1'b0;
         end
      end
   end

   // Outputs
   always_comb begin
      result.valid            = 1'b0;
      result.rsp.kind         = KIND_DATA;
      result.rsp.payload_byte = 8'd0;
      result.rsp.frame_last   = 1'b0;
      unique case (phase_ff)
         PH_HDR0: begin
            if (op_invalid) begin
               result.valid    = accept;
               result.rsp.kind = KIND_INVALID;
            end else if (opcode == OP_PING) begin
               result.valid    = accept;
               result.rsp.kind = KIND_PONG;
            end
         end
         PH_PAYLOAD: begin
            result.valid            = accept;
            result.rsp.payload_byte = req.data_byte ^ key_byte;
            result.rsp.frame_last   = payload_fin;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         header_count_ff <= 4'd0;
         remaining_ff    <= 64'd0;
         mask_key_ff     <= 32'd0;
         mask_index_ff   <= 2'd0;
         masked_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         remaining_ff    <= remaining_in;
         mask_key_ff     <= mask_key_in;
         mask_index_ff   <= mask_index_in;
         masked_ff       <= masked_in;
      end
   end

   `WSFD_ASSERT_NXT(a_buf_end_to_hdr, clock, reset, accept && req.buffer_last, phase_ff == PH_HDR0)
   `WSFD_ASSERT_IMP(a_payload_emits, clock, reset, accept && phase_ff == PH_PAYLOAD, result.valid)
   `WSFD_ASSERT_IMP(a_last_is_data, clock, reset, result.valid && result.rsp.frame_last, result.rsp.kind == KIND_DATA)

endmodule

// File: rtl/wsfd_out_reg.sv
// Result register between the parser and the response channel.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_unit_macros.svh"
module wsfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  wsfd_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output wsfd_pkg::rsp_type    rsp_data,
   output logic                 full_stalled
);
   import wsfd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   assign full_stalled = valid_ff && rsp_stall;

   always_comb begin
      valid_in = result.valid ? 1'b1 : full_stalled;
      data_in  = result.valid ? result.rsp : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `WSFD_ASSERT_IMP(a_no_overwrite, clock, reset, result.valid, !full_stalled)
   `WSFD_ASSERT_NXT(a_hold_stalled, clock, reset, full_stalled, valid_ff && data_ff == $past(data_ff))
   `WSFD_ASSERT_NXT(a_no_phantom, clock, reset, !full_stalled && !result.valid, !valid_ff)

endmodule

// File: rtl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer.
`timescale 1ns / 1ps
// Receive-side WebSocket deframer. Feed received bytes one per transaction on
// the req_ channel, with buffer_last set on the last byte of each receive
// buffer; that byte returns the parser to the frame header no matter where it
// was. Each byte yields zero or one rsp_ transaction: an unmasked payload byte
// (frame_last set on the final byte of a frame), a pong request when a ping
// header arrives, or an invalid-frame report for a reserved opcode. Ping,
// continuation, reserved, unmasked and zero-length frames drop the rest of
// the buffer. The length field is held in full 64 bits. Throughput is one
// byte per clock while req_stall is low: parser state updates in the cycle
// a byte is taken; its result shows from a single output register the next cycle.
// req_stall is raised only while that register is full and rsp_stall is high.
module websocket_frame_deframer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wsfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsfd_pkg::rsp_type rsp_data
);
   import wsfd_pkg::*;

   logic       accept;
   logic       full_stalled;
   result_type result;

   // Take a byte whenever the output register can absorb its result.
   assign req_stall = full_stalled;
   assign accept    = req_valid && !full_stalled;

   wsfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .result (result)
   );

   // Hold the result here until the consumer takes it.
   wsfd_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .full_stalled (full_stalled)
   );

endmodule

// File: tb/sv/tb_websocket_frame_deframer_unit.sv
// Self-checking testbench of the WebSocket frame deframer unit.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer_unit;
   import wsfd_pkg::*;

   // Opcodes that the parser accepts as frame headers, besides the package codes.
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Cycles without any accepted transaction before the run is declared hung.
   localparam int QUIET_LIMIT = 5000;
   // Margin waited after the last predicted result has come out.
   localparam int SETTLE_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   websocket_frame_deframer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle rates of the two sides, in percent of cycles.
   int unsigned sender_idle_pct = 35;
   int unsigned receiver_stall_pct = 61;

   rsp_type     expected_frames_q[$];  // unmasked bytes and reports still to come
   req_type     stream_q[$];           // bytes of the receive buffer being built
   int unsigned parsed_count = 0;      // transactions the parser did not simply drop
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   // Parser state mirrored by the predictor.
   phase_type   prs_phase;
   logic [3:0]  prs_count;
   logic [63:0] prs_remaining;
   logic [31:0] prs_key;
   logic [1:0]  prs_index;
   logic        prs_masked;

   function automatic void clear_parser();
      prs_phase     = PH_HDR0;
      prs_count     = '0;
      prs_remaining = '0;
      prs_key       = '0;
      prs_index     = '0;
      prs_masked    = 1'b0;
   endfunction

   // Length is complete: a masked frame goes on to its key, anything else is dropped.
   function automatic void length_known();
      if (prs_masked) begin
         prs_phase = PH_MASKKEY;
         prs_count = KEY_BYTES;
      end else begin
         prs_phase = PH_DISCARD;
      end
   endfunction

   // Advance the mirrored parser by one byte; return 1 when the byte yields a result.
   function automatic bit deframe_byte(input logic [7:0] data, input logic last,
                                       output rsp_type res);
      logic [3:0] op;
      logic [7:0] key_byte;
      bit         hit;
      hit = 1'b0;
      res = '0;
      op  = data[3:0];
      case (prs_phase)
         PH_HDR0: begin
            if ((op > OP_RSV_LO && op < OP_RSV_HI) || op > OP_CTRL_MAX) begin
               res.kind  = KIND_INVALID;
               hit       = 1'b1;
               prs_phase = PH_DISCARD;
            end else if (op == OP_CONT) begin
               prs_phase = PH_DISCARD;
            end else if (op == OP_PING) begin
               res.kind  = KIND_PONG;
               hit       = 1'b1;
               prs_phase = PH_DISCARD;
            end else begin
               prs_phase = PH_HDR1;
            end
         end
         PH_HDR1: begin
            prs_masked    = data[7];
            prs_remaining = '0;
            if (data[6:0] == LEN_EXT16) begin
               prs_phase = PH_EXTLEN;
               prs_count = EXT16_BYTES;
            end else if (data[6:0] == LEN_EXT64) begin
               prs_phase = PH_EXTLEN;
               prs_count = EXT64_BYTES;
            end else begin
               prs_remaining = 64'(data[6:0]);
               length_known();
            end
         end
         PH_EXTLEN: begin
            prs_remaining = {prs_remaining[55:0], data};
            prs_count     = prs_count - 4'd1;
            if (prs_count == '0) length_known();
         end
         PH_MASKKEY: begin
            prs_key   = {prs_key[23:0], data};
            prs_count = prs_count - 4'd1;
            if (prs_count == '0) begin
               prs_index = '0;
               prs_phase = (prs_remaining == '0) ? PH_DISCARD : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            // Key bytes rotate from the most significant one.
            key_byte         = 8'(prs_key >> (8 * (3 - prs_index)));
            prs_index        = prs_index + 2'd1;
            prs_remaining    = prs_remaining - 64'd1;
            res.kind         = KIND_DATA;
            res.payload_byte = data ^ key_byte;
            res.frame_last   = (prs_remaining == '0);
            hit              = 1'b1;
            if (res.frame_last) begin
               prs_phase = PH_HDR0;
               prs_count = '0;
               prs_index = '0;
            end
         end
         default: ;
      endcase
      if (last) clear_parser();
      return hit;
   endfunction

   initial clear_parser();

   // Offer one byte, idling at random first; predict its result once accepted.
   task automatic send_byte(input logic [7:0] data, input logic last);
      rsp_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: data, buffer_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (prs_phase != PH_DISCARD || last) parsed_count++;
      if (deframe_byte(data, last, res)) expected_frames_q.push_back(res);
      @(negedge clock);
   endtask

   // Hold the input channel idle until every predicted result has come out.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_frames_q.size() != 0);
   endtask

   function automatic void push_byte(input logic [7:0] data, input logic last);
      req_type item;
      item.data_byte   = data;
      item.buffer_last = last;
      stream_q.push_back(item);
   endfunction

   // Append one frame to the buffer; ends is set when the parser drops what follows or the frame is cut short.
   task automatic append_frame(output bit ends);
      logic [3:0]  op;
      logic [63:0] len;
      logic [6:0]  len7;
      logic        masked;
      int unsigned pick, k, nlen, npay;
      ends = 1'b1;
      pick = $urandom_range(99);
      if (pick < 5) begin
         op = OP_PING;
      end else if (pick < 9) begin
         op = OP_CONT;
      end else if (pick < 16) begin
         k  = $urandom_range(7);
         op = (k < 4) ? 4'(OP_RSV_LO + 1 + k) : 4'(OP_CTRL_MAX + 1 + (k - 4));
      end else begin
         case ($urandom_range(4))
            0:       op = OP_TEXT;
            1:       op = OP_BINARY;
            2:       op = OP_CLOSE;
            3:       op = OP_PONG;
            default: op = OP_CTRL_MAX;
         endcase
      end
      push_byte({4'($urandom), op}, 1'b0);
      if (pick < 16) return;

      // Mostly short masked frames; some extended lengths, a few of them huge.
      masked = ($urandom_range(9) != 0);
      pick   = $urandom_range(99);
      nlen   = 0;
      if (pick < 70) begin
         len = 64'($urandom_range(12));
      end else if (pick < 80) begin
         len = 64'($urandom_range(125));
      end else if (pick < 90) begin
         nlen = 2;
         len  = ($urandom_range(3) == 0) ? 64'($urandom_range(65535))
                                         : 64'($urandom_range(40));
      end else begin
         nlen = 8;
         len  = ($urandom_range(1) == 0) ? {$urandom, $urandom} : 64'($urandom_range(40));
      end
      len7 = (nlen == 2) ? LEN_EXT16 : (nlen == 8) ? LEN_EXT64 : len[6:0];
      push_byte({masked, len7}, 1'b0);
      for (int i = nlen; i > 0; i--) push_byte(8'(len >> (8 * (i - 1))), 1'b0);
      if (!masked) return;
      repeat (4) push_byte(8'($urandom), 1'b0);
      if (len == '0) return;
      // Cut long frames short; the buffer end then stops them mid-payload.
      if (len > 64) begin
         npay = $urandom_range(30);
      end else begin
         npay = int'(len);
         ends = 1'b0;
      end
      repeat (npay) push_byte(8'($urandom), 1'b0);
   endtask

   // Build one receive buffer: frames back to back, now and then noise or a cut.
   task automatic build_buffer();
      req_type     tail;
      bit          ends;
      int unsigned nframes, cut;
      stream_q.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(3) == 0);
      end else begin
         nframes = $urandom_range(1, 4);
         ends    = 1'b0;
         while (nframes != 0 && !ends) begin
            append_frame(ends);
            nframes--;
         end
         if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) tail = stream_q.pop_back();
         end
         // Bytes behind a dropped frame must vanish; behind a cut frame they are payload.
         if (ends && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
      end
      tail             = stream_q.pop_back();
      tail.buffer_last = 1'b1;
      stream_q.push_back(tail);
   endtask

   // Every opcode, each one closing its own buffer; pings, unmasked and
   // zero-length frames are followed by bytes that must be dropped.
   task automatic test_opcodes();
      logic [3:0] op;
      logic [7:0] hdr;
      for (int i = 0; i < 16; i++) begin
         op  = 4'(i);
         hdr = {(op == OP_CONT) ? 4'h0 : (&op) ? 4'hF : 4'($urandom), op};
         if (op == OP_PING) begin
            send_byte(hdr, 1'b0);
            send_byte({4'h8, OP_PING}, 1'b1);
         end else if (op == OP_TEXT) begin
            send_byte(hdr, 1'b0);
            send_byte({1'b0, 7'd5}, 1'b0);
            send_byte({4'h8, OP_PING}, 1'b1);
         end else if (op == OP_BINARY) begin
            send_byte(hdr, 1'b0);
            send_byte({1'b1, 7'd0}, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'hFF, 1'b0);
            send_byte(8'h12, 1'b0);
            send_byte(8'h34, 1'b0);
            send_byte({4'h8, OP_PING}, 1'b1);
         end else begin
            send_byte(hdr, 1'b1);
         end
      end
   endtask

   // Masked frame with a 16-bit length; pause the sender between its two payload bytes.
   task automatic test_extended_frame();
      send_byte({4'h8, OP_BINARY}, 1'b0);
      send_byte({1'b1, LEN_EXT16}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h3C, 1'b0);
      hold_until_drained();
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_random_traffic(input int unsigned goal);
      int unsigned stop_at;
      stop_at = parsed_count + goal;
      while (parsed_count < stop_at) begin
         build_buffer();
         foreach (stream_q[i]) send_byte(stream_q[i].data_byte, stream_q[i].buffer_last);
         if ($urandom_range(24) == 0) hold_until_drained();
      end
   endtask

   // Receiver side: stall at random, change only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result kind %0d byte %02h last %0d",
                        $time, rsp_data.kind, rsp_data.payload_byte, rsp_data.frame_last);
         end else begin
            want = expected_frames_q.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.payload_byte !== want.payload_byte ||
                rsp_data.frame_last !== want.frame_last) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                           $time, want.kind, want.payload_byte, want.frame_last,
                           rsp_data.kind, rsp_data.payload_byte, rsp_data.frame_last);
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_opcodes();
      test_extended_frame();
      test_random_traffic(440);

      sender_idle_pct    = 61;
      receiver_stall_pct = 35;
      test_random_traffic(440);

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      test_random_traffic(440);

      req_valid <= 1'b0;
      while (expected_frames_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_frames_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
